/* rtl/bbc_pkg.sv */
// Package: opcodes, status codes and payload types of the LRU buffer cache.
`timescale 1ns / 1ps
`default_nettype none
package bbc_pkg;
  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_DIRTY   = 2'd2,
    OP_DONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_BUFFER = 2'd1,
    ST_NOT_HELD  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [4:0]  slot;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] granted_slot;
    logic       was_hit;
    logic       needs_read;
  } rsp_t;

  localparam int unsigned SlotW = 5;
  localparam logic [7:0] UseMax = 8'hFF;
endpackage
`default_nettype wire

/* rtl/bbc_if.sv */
// Interface: valid/ready channel carrying one payload word.
`timescale 1ns / 1ps
`default_nettype none
interface bbc_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/bbc_cell.sv */
// Cell: one recency position, holding one slot's tag, flags and count.
`timescale 1ns / 1ps
`default_nettype none
module bbc_cell #(
  parameter int unsigned IdW = 5
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [IdW-1:0] rst_id_i,
  // neighbor toward the most recent end
  input  wire logic [IdW-1:0] nb_id_i,
  input  wire logic [7:0]     nb_dev_i,
  input  wire logic [31:0]    nb_blk_i,
  input  wire logic [7:0]     nb_cnt_i,
  input  wire logic           nb_val_i,
  input  wire logic           nb_dty_i,
  // control
  input  wire logic           shift_i,   // take neighbor contents
  input  wire logic           load_i,    // take front contents
  input  wire logic [IdW-1:0] ld_id_i,
  input  wire logic [7:0]     ld_dev_i,
  input  wire logic [31:0]    ld_blk_i,
  input  wire logic [7:0]     ld_cnt_i,
  input  wire logic           ld_val_i,
  input  wire logic           ld_dty_i,
  input  wire logic           wr_i,      // update this cell in place
  input  wire logic [7:0]     wr_dev_i,
  input  wire logic [31:0]    wr_blk_i,
  input  wire logic [7:0]     wr_cnt_i,
  input  wire logic           wr_val_i,
  input  wire logic           wr_dty_i,
  output logic [IdW-1:0]      id_o,
  output logic [7:0]          dev_o,
  output logic [31:0]         blk_o,
  output logic [7:0]          cnt_o,
  output logic                val_o,
  output logic                dty_o
);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_o <= rst_id_i; dev_o <= '0; blk_o <= '0;
      cnt_o <= '0; val_o <= 1'b0; dty_o <= 1'b0;
    end else if (load_i) begin
      id_o <= ld_id_i; dev_o <= ld_dev_i; blk_o <= ld_blk_i;
      cnt_o <= ld_cnt_i; val_o <= ld_val_i; dty_o <= ld_dty_i;
    end else if (shift_i) begin
      id_o <= nb_id_i; dev_o <= nb_dev_i; blk_o <= nb_blk_i;
      cnt_o <= nb_cnt_i; val_o <= nb_val_i; dty_o <= nb_dty_i;
    end else if (wr_i) begin
      dev_o <= wr_dev_i; blk_o <= wr_blk_i;
      cnt_o <= wr_cnt_i; val_o <= wr_val_i; dty_o <= wr_dty_i;
    end
  end
endmodule
`default_nettype wire

/* rtl/block_buffer_cache_lru_core.sv */
// Top level: LRU block buffer cache tag manager built as a chain of cells.
`timescale 1ns / 1ps
`default_nettype none
// A request word is registered on acceptance; in the next cycle each cell of
// the recency chain compares its tag in parallel, priority encoders pick the
// most recent hit and the least recent free clean cell, and the chain updates
// (cells ahead of a released slot shift one place toward the tail while the
// slot reloads at the head). The result sits in an output register; a new
// request is taken once none is in work and that register is free or being
// drained. Position 0 is the most recent; each cell carries its slot number.
module block_buffer_cache_lru_core #(
  parameter int unsigned NUM_BUFFERS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bbc_if.sink       req_i,
  bbc_if.source     rsp_o
);
  localparam int unsigned IdW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int unsigned N = NUM_BUFFERS;

  logic [IdW-1:0] id   [N];
  logic [7:0]     dev  [N];
  logic [31:0]    blk  [N];
  logic [7:0]     cnt  [N];
  logic           val  [N];
  logic           dty  [N];

  logic            busy_q;
  bbc_pkg::req_t   req_q;
  logic            ov_q;
  bbc_pkg::rsp_t   rsp_q;

  // accept while no request is in work and the result slot is free or drains
  assign req_i.ready = !busy_q && (!ov_q || rsp_o.ready);
  assign rsp_o.valid = ov_q;
  assign rsp_o.data  = rsp_q;

  // match and search
  logic [N-1:0] hit_v, free_v, sel_v;
  logic         hit_f, free_f, sel_f;
  logic [IdW-1:0] hit_p, free_p, sel_p;
  logic in_range;
  always_comb begin
    for (int p = 0; p < N; p++) begin
      hit_v[p]  = dev[p] == req_q.device && blk[p] == req_q.block_number;
      free_v[p] = cnt[p] == 8'd0 && !dty[p];
      sel_v[p]  = {{(32-IdW){1'b0}}, id[p]} == 32'(req_q.slot);
    end
    hit_f = 1'b0; hit_p = '0;
    for (int p = N - 1; p >= 0; p--)
      if (hit_v[p]) begin hit_f = 1'b1; hit_p = IdW'(p); end
    free_f = 1'b0; free_p = '0;
    for (int p = 0; p < N; p++)
      if (free_v[p]) begin free_f = 1'b1; free_p = IdW'(p); end
    sel_f = 1'b0; sel_p = '0;
    for (int p = 0; p < N; p++)
      if (sel_v[p]) begin sel_f = 1'b1; sel_p = IdW'(p); end
    in_range = sel_f;
  end

  // per-request decision
  logic           wr_en, mtf;
  logic [IdW-1:0] wr_p;
  logic [7:0]     w_cnt;
  logic [7:0]     w_dev;
  logic [31:0]    w_blk;
  logic           w_val, w_dty;
  bbc_pkg::rsp_t  rsp_d;
  always_comb begin
    wr_en = 1'b0; mtf = 1'b0; wr_p = sel_p;
    w_dev = dev[sel_p]; w_blk = blk[sel_p]; w_cnt = cnt[sel_p];
    w_val = val[sel_p]; w_dty = dty[sel_p];
    rsp_d = '0;
    unique case (bbc_pkg::op_e'(req_q.op))
      bbc_pkg::OP_GET: begin
        if (hit_f) begin
          wr_en = 1'b1; wr_p = hit_p;
          w_dev = dev[hit_p]; w_blk = blk[hit_p];
          w_cnt = (cnt[hit_p] == bbc_pkg::UseMax) ? cnt[hit_p] : cnt[hit_p] + 8'd1;
          w_val = val[hit_p]; w_dty = dty[hit_p];
          rsp_d.granted_slot = bbc_pkg::SlotW'(id[hit_p]);
          rsp_d.was_hit = 1'b1;
          rsp_d.needs_read = !val[hit_p];
        end else if (free_f) begin
          wr_en = 1'b1; wr_p = free_p;
          w_dev = req_q.device; w_blk = req_q.block_number;
          w_cnt = 8'd1; w_val = 1'b0; w_dty = 1'b0;
          rsp_d.granted_slot = bbc_pkg::SlotW'(id[free_p]);
          rsp_d.needs_read = 1'b1;
        end else begin
          rsp_d.status = bbc_pkg::ST_NO_BUFFER;
        end
      end
      bbc_pkg::OP_RELEASE: begin
        if (!in_range || cnt[sel_p] == 8'd0) begin
          rsp_d.status = bbc_pkg::ST_NOT_HELD;
        end else begin
          w_cnt = cnt[sel_p] - 8'd1;
          if (w_cnt == 8'd0) mtf = 1'b1;
          else wr_en = 1'b1;
        end
      end
      bbc_pkg::OP_DIRTY: begin
        wr_en = in_range; w_dty = 1'b1;
      end
      bbc_pkg::OP_DONE: begin
        wr_en = in_range; w_val = 1'b1; w_dty = 1'b0;
      end
      default: ;
    endcase
  end

  logic go;
  assign go = busy_q;

  for (genvar p = 0; p < N; p++) begin : g_cell
    localparam int unsigned Pm = (p == 0) ? 0 : p - 1;
    bbc_cell #(.IdW(IdW)) u_cell (
      .clk_i, .rst_ni,
      .rst_id_i (IdW'(N - 1 - p)),
      .nb_id_i  (id[Pm]), .nb_dev_i (dev[Pm]), .nb_blk_i (blk[Pm]),
      .nb_cnt_i (cnt[Pm]), .nb_val_i (val[Pm]), .nb_dty_i (dty[Pm]),
      .shift_i  (go && mtf && p != 0 && IdW'(p) <= sel_p),
      .load_i   (go && mtf && p == 0),
      .ld_id_i  (id[sel_p]), .ld_dev_i (dev[sel_p]), .ld_blk_i (blk[sel_p]),
      .ld_cnt_i (8'd0), .ld_val_i (val[sel_p]), .ld_dty_i (dty[sel_p]),
      .wr_i     (go && wr_en && wr_p == IdW'(p)),
      .wr_dev_i (w_dev), .wr_blk_i (w_blk), .wr_cnt_i (w_cnt),
      .wr_val_i (w_val), .wr_dty_i (w_dty),
      .id_o (id[p]), .dev_o (dev[p]), .blk_o (blk[p]),
      .cnt_o (cnt[p]), .val_o (val[p]), .dty_o (dty[p])
    );
  end

  // hold the request, then post the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (req_i.valid && req_i.ready) busy_q <= 1'b1;
      else if (busy_q) busy_q <= 1'b0;
      if (busy_q) ov_q <= 1'b1;
      else if (rsp_o.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) req_q <= req_i.data;
    if (busy_q) rsp_q <= rsp_d;
  end

`ifndef ASSERT_OFF
  a_busy_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> !busy_q) else $error("request held more than one cycle");
  a_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> ov_q) else $error("result not posted");
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.ready) else $error("request taken while busy");
`endif
endmodule
`default_nettype wire
